[rtl/gqat_pkg.sv]
// ----------------------------------------------------------------------------
// gqat_pkg
// Shared types, widths and constants of the glyph quad affine transform core.
// ----------------------------------------------------------------------------
package gqat_pkg;

  localparam int MAX_GLYPHS  = 4096;
  localparam int FRAC_BITS   = 16;
  localparam int LOCAL_BITS  = 46;

  localparam int COORD_W     = 32;
  localparam int TRIG_W      = 18;
  localparam int BASE_W      = 14;
  localparam int NUM_LANES   = 4;
  localparam int LANE_STAGES = 5;
  localparam int CNT_W       = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
  localparam int CFG_IDX_W   = 3;

  localparam int DIFF_W      = COORD_W + 1;
  localparam int PROD_W      = DIFF_W + COORD_W;
  localparam int ROT_PROD_W  = LOCAL_BITS + TRIG_W;
  localparam int ROT_SUM_W   = ROT_PROD_W + 1;
  localparam int RES_W       = ROT_SUM_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_SCALE_X  = 3'd2,
    CFG_SCALE_Y  = 3'd3,
    CFG_ROT_COS  = 3'd4,
    CFG_ROT_SIN  = 3'd5,
    CFG_POS_X    = 3'd6,
    CFG_POS_Y    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] scale_x;
    logic signed [COORD_W-1:0] scale_y;
    logic signed [TRIG_W-1:0]  rot_cos;
    logic signed [TRIG_W-1:0]  rot_sin;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
  } xform_cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic                      sat;
  } lane_res_t;

endpackage

[rtl/gqat_lane.sv]
// ----------------------------------------------------------------------------
// gqat_lane
// One corner: origin subtract, per-axis scale with clamp, rotate, translate
// and clamp to 32 bits. Five registered stages, all advancing on en.
// ----------------------------------------------------------------------------
module gqat_lane
  import gqat_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  xform_cfg_t                cfg,
  input  logic signed [COORD_W-1:0] x_i,
  input  logic signed [COORD_W-1:0] y_i,
  output lane_res_t                 res_o
);

  localparam logic signed [PROD_W-1:0] LOC_MAX =
    (PROD_W'(1) << (LOCAL_BITS - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] LOC_MIN = ~LOC_MAX;
  localparam logic signed [RES_W-1:0]  OUT_MAX =
    (RES_W'(1) << (COORD_W - 1)) - RES_W'(1);
  localparam logic signed [RES_W-1:0]  OUT_MIN = ~OUT_MAX;

  logic signed [DIFF_W-1:0]     dx_r, dy_r, dx_nxt, dy_nxt;
  logic signed [PROD_W-1:0]     px_r, py_r, px_nxt, py_nxt;
  logic signed [PROD_W-1:0]     shx, shy;
  logic signed [LOCAL_BITS-1:0] lx_r, ly_r, lx_nxt, ly_nxt;
  logic                         sat3_r, sat3_nxt;
  logic signed [ROT_PROD_W-1:0] lxc_r, lys_r, lxs_r, lyc_r;
  logic signed [ROT_PROD_W-1:0] lxc_nxt, lys_nxt, lxs_nxt, lyc_nxt;
  logic                         sat4_r;
  logic signed [ROT_SUM_W-1:0]  sumx, sumy;
  logic signed [RES_W-1:0]      resx, resy;
  lane_res_t                    res_r, res_nxt;

  always_comb begin
    dx_nxt = DIFF_W'(x_i) - DIFF_W'(cfg.origin_x);
    dy_nxt = DIFF_W'(y_i) - DIFF_W'(cfg.origin_y);
    px_nxt = dx_r * cfg.scale_x;
    py_nxt = dy_r * cfg.scale_y;

    shx = px_r >>> FRAC_BITS;
    shy = py_r >>> FRAC_BITS;
    sat3_nxt = 1'b0;
    if (shx > LOC_MAX) begin
      lx_nxt = LOC_MAX[LOCAL_BITS-1:0];
      sat3_nxt = 1'b1;
    end else if (shx < LOC_MIN) begin
      lx_nxt = LOC_MIN[LOCAL_BITS-1:0];
      sat3_nxt = 1'b1;
    end else begin
      lx_nxt = shx[LOCAL_BITS-1:0];
    end
    if (shy > LOC_MAX) begin
      ly_nxt = LOC_MAX[LOCAL_BITS-1:0];
      sat3_nxt = 1'b1;
    end else if (shy < LOC_MIN) begin
      ly_nxt = LOC_MIN[LOCAL_BITS-1:0];
      sat3_nxt = 1'b1;
    end else begin
      ly_nxt = shy[LOCAL_BITS-1:0];
    end

    lxc_nxt = lx_r * cfg.rot_cos;
    lys_nxt = ly_r * cfg.rot_sin;
    lxs_nxt = lx_r * cfg.rot_sin;
    lyc_nxt = ly_r * cfg.rot_cos;

    sumx = ROT_SUM_W'(lxc_r) - ROT_SUM_W'(lys_r);
    sumy = ROT_SUM_W'(lxs_r) + ROT_SUM_W'(lyc_r);
    resx = RES_W'(sumx >>> FRAC_BITS) + RES_W'(cfg.pos_x);
    resy = RES_W'(sumy >>> FRAC_BITS) + RES_W'(cfg.pos_y);
    res_nxt.sat = sat4_r;
    if (resx > OUT_MAX) begin
      res_nxt.ox = OUT_MAX[COORD_W-1:0];
      res_nxt.sat = 1'b1;
    end else if (resx < OUT_MIN) begin
      res_nxt.ox = OUT_MIN[COORD_W-1:0];
      res_nxt.sat = 1'b1;
    end else begin
      res_nxt.ox = resx[COORD_W-1:0];
    end
    if (resy > OUT_MAX) begin
      res_nxt.oy = OUT_MAX[COORD_W-1:0];
      res_nxt.sat = 1'b1;
    end else if (resy < OUT_MIN) begin
      res_nxt.oy = OUT_MIN[COORD_W-1:0];
      res_nxt.sat = 1'b1;
    end else begin
      res_nxt.oy = resy[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      lx_r   <= lx_nxt;
      ly_r   <= ly_nxt;
      sat3_r <= sat3_nxt;
      lxc_r  <= lxc_nxt;
      lys_r  <= lys_nxt;
      lxs_r  <= lxs_nxt;
      lyc_r  <= lyc_nxt;
      sat4_r <= sat3_r;
      res_r  <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

[rtl/gqat_merge.sv]
// ----------------------------------------------------------------------------
// gqat_merge
// Output register: gathers the four lane results, ORs the clamp flags and
// pairs them with the quad's base index.
// ----------------------------------------------------------------------------
module gqat_merge
  import gqat_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  lane_res_t                 lane_i [NUM_LANES],
  input  logic [BASE_W-1:0]         base_i,
  output lane_res_t                 corner_o [NUM_LANES],
  output logic [BASE_W-1:0]         base_o,
  output logic                      sat_o
);

  lane_res_t         corner_r [NUM_LANES];
  logic [BASE_W-1:0] base_r;
  logic              sat_r, sat_nxt;

  always_comb begin
    sat_nxt = 1'b0;
    for (int i = 0; i < NUM_LANES; i++) begin
      sat_nxt = sat_nxt | lane_i[i].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      corner_r <= lane_i;
      base_r   <= base_i;
      sat_r    <= sat_nxt;
    end
  end

  assign corner_o = corner_r;
  assign base_o   = base_r;
  assign sat_o    = sat_r;

endmodule

[rtl/glyph_quad_affine_transform_core.sv]
// ----------------------------------------------------------------------------
// glyph_quad_affine_transform_core
// Affine transform of one glyph quad per transaction: four corner lanes and a
// merge stage, with the glyph counter and configuration registers.
//
//   channel  handshake              payload
//   in_      in_valid / in_ready    in_first_glyph, in_x0..in_y3
//   out_     out_valid / out_ready  out_base_index, out_x0..out_y3, out_saturated
//   cfg_     cfg_we                 cfg_index, cfg_wdata
//
// One transaction per cycle unless the output stalls; the path is five lane
// stages plus the merge register, the lane stages being the subtract, scale,
// clamp, rotate and translate steps of each corner lane, one register each.
// A stalled output holds the whole pipeline; in_ready drops only then.
// Synchronous active-low reset clears valid bits and counter, loads identity cfg.
// ----------------------------------------------------------------------------
module glyph_quad_affine_transform_core
  import gqat_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_first_glyph,
  input  logic signed [COORD_W-1:0] in_x0,
  input  logic signed [COORD_W-1:0] in_y0,
  input  logic signed [COORD_W-1:0] in_x1,
  input  logic signed [COORD_W-1:0] in_y1,
  input  logic signed [COORD_W-1:0] in_x2,
  input  logic signed [COORD_W-1:0] in_y2,
  input  logic signed [COORD_W-1:0] in_x3,
  input  logic signed [COORD_W-1:0] in_y3,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [BASE_W-1:0]         out_base_index,
  output logic signed [COORD_W-1:0] out_x0,
  output logic signed [COORD_W-1:0] out_y0,
  output logic signed [COORD_W-1:0] out_x1,
  output logic signed [COORD_W-1:0] out_y1,
  output logic signed [COORD_W-1:0] out_x2,
  output logic signed [COORD_W-1:0] out_y2,
  output logic signed [COORD_W-1:0] out_x3,
  output logic signed [COORD_W-1:0] out_y3,
  output logic                      out_saturated,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_W-1:0]        cfg_wdata
);

  xform_cfg_t                cfg_r;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt, cur;
  logic [LANE_STAGES:0]      vld_r;
  logic [BASE_W-1:0]         base_pipe_r [LANE_STAGES];
  logic [BASE_W-1:0]         base_nxt;
  logic                      adv, in_acc;
  logic signed [COORD_W-1:0] xs [NUM_LANES];
  logic signed [COORD_W-1:0] ys [NUM_LANES];
  lane_res_t                 lane_res [NUM_LANES];
  lane_res_t                 corner [NUM_LANES];

  assign adv      = !vld_r[LANE_STAGES] || out_ready;
  assign in_ready = adv;
  assign in_acc   = in_valid && adv;

  always_comb begin
    cur = in_first_glyph ? '0 : cnt_r;
    if (cur == CNT_W'(MAX_GLYPHS - 1)) begin
      cnt_nxt = '0;
    end else begin
      cnt_nxt = cur + CNT_W'(1);
    end
    base_nxt = BASE_W'({cur, 2'b00});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x <= '0;
      cfg_r.origin_y <= '0;
      cfg_r.scale_x  <= COORD_W'(1 << FRAC_BITS);
      cfg_r.scale_y  <= COORD_W'(1 << FRAC_BITS);
      cfg_r.rot_cos  <= TRIG_W'(1 << FRAC_BITS);
      cfg_r.rot_sin  <= '0;
      cfg_r.pos_x    <= '0;
      cfg_r.pos_y    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN_X: cfg_r.origin_x <= cfg_wdata;
        CFG_ORIGIN_Y: cfg_r.origin_y <= cfg_wdata;
        CFG_SCALE_X:  cfg_r.scale_x  <= cfg_wdata;
        CFG_SCALE_Y:  cfg_r.scale_y  <= cfg_wdata;
        CFG_ROT_COS:  cfg_r.rot_cos  <= cfg_wdata[TRIG_W-1:0];
        CFG_ROT_SIN:  cfg_r.rot_sin  <= cfg_wdata[TRIG_W-1:0];
        CFG_POS_X:    cfg_r.pos_x    <= cfg_wdata;
        CFG_POS_Y:    cfg_r.pos_y    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LANE_STAGES-1:0], in_valid};
      if (in_acc) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      base_pipe_r[0] <= base_nxt;
      for (int i = 1; i < LANE_STAGES; i++) begin
        base_pipe_r[i] <= base_pipe_r[i-1];
      end
    end
  end

  assign xs[0] = in_x0;
  assign ys[0] = in_y0;
  assign xs[1] = in_x1;
  assign ys[1] = in_y1;
  assign xs[2] = in_x2;
  assign ys[2] = in_y2;
  assign xs[3] = in_x3;
  assign ys[3] = in_y3;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    gqat_lane u_lane (
      .clk   (clk),
      .en    (adv),
      .cfg   (cfg_r),
      .x_i   (xs[g]),
      .y_i   (ys[g]),
      .res_o (lane_res[g])
    );
  end

  gqat_merge u_merge (
    .clk      (clk),
    .en       (adv),
    .lane_i   (lane_res),
    .base_i   (base_pipe_r[LANE_STAGES-1]),
    .corner_o (corner),
    .base_o   (out_base_index),
    .sat_o    (out_saturated)
  );

  assign out_valid = vld_r[LANE_STAGES];
  assign out_x0    = corner[0].ox;
  assign out_y0    = corner[0].oy;
  assign out_x1    = corner[1].ox;
  assign out_y1    = corner[1].oy;
  assign out_x2    = corner[2].ox;
  assign out_y2    = corner[2].oy;
  assign out_x3    = corner[3].ox;
  assign out_y3    = corner[3].oy;

endmodule

[test/glyph_quad_affine_transform_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_quad_affine_transform_core_tb
// Streams glyph quads through the transform core under random handshake
// gaps and stalls. An in-bench predictor applies the origin, scale, rotation,
// translation and saturation steps with exact wide arithmetic and tracks the
// glyph counter. Every result is checked field by field in order. The run
// covers directed edge values and well-formed and raw random quads over many
// register settings.
// ----------------------------------------------------------------------------
module glyph_quad_affine_transform_core_tb;
  import gqat_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LATENCY     = LANE_STAGES + 1;

  typedef struct packed {
    logic                          first;
    logic [NUM_LANES-1:0][COORD_W-1:0] x;
    logic [NUM_LANES-1:0][COORD_W-1:0] y;
  } quad_item_t;

  typedef struct packed {
    logic [BASE_W-1:0]             base;
    logic [NUM_LANES-1:0][COORD_W-1:0] x;
    logic [NUM_LANES-1:0][COORD_W-1:0] y;
    logic                          sat;
  } quad_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_first_glyph = 1'b0;
  logic signed [COORD_W-1:0] in_x0 = '0, in_y0 = '0, in_x1 = '0, in_y1 = '0;
  logic signed [COORD_W-1:0] in_x2 = '0, in_y2 = '0, in_x3 = '0, in_y3 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [BASE_W-1:0] out_base_index;
  logic signed [COORD_W-1:0] out_x0, out_y0, out_x1, out_y1;
  logic signed [COORD_W-1:0] out_x2, out_y2, out_x3, out_y3;
  logic out_saturated;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0] cfg_wdata = '0;

  xform_cfg_t xf;
  quad_item_t quads_to_send[$];
  quad_result_t expected_corners[$];
  logic [CNT_W-1:0] glyph_next;
  quad_item_t tx_item;
  int mismatch_count = 0;
  int cycle_count = 0;
  int quiet_left[2] = '{0, 0};
  int tx_gap = 0;
  int rx_stall = 0;

  glyph_quad_affine_transform_core dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic quad_result_t transform_quad(quad_item_t q, logic [CNT_W-1:0] glyph);
    quad_result_t r;
    logic signed [127:0] dx, dy, lx, ly, rx, ry;
    logic signed [127:0] ox_w, oy_w, sx_w, sy_w, c_w, s_w, px_w, py_w;
    logic signed [127:0] loc_max, loc_min, w_max, w_min;
    int k;
    loc_max = (128'sd1 <<< (LOCAL_BITS - 1)) - 128'sd1;
    loc_min = -loc_max - 128'sd1;
    w_max = 128'sd2147483647;
    w_min = -w_max - 128'sd1;
    ox_w = xf.origin_x;
    oy_w = xf.origin_y;
    sx_w = xf.scale_x;
    sy_w = xf.scale_y;
    c_w = xf.rot_cos;
    s_w = xf.rot_sin;
    px_w = xf.pos_x;
    py_w = xf.pos_y;
    r.base = {glyph, 2'b00};
    r.sat = 1'b0;
    for (k = 0; k < NUM_LANES; k++) begin
      dx = signed'(q.x[k]);
      dy = signed'(q.y[k]);
      lx = ((dx - ox_w) * sx_w) >>> FRAC_BITS;
      ly = ((dy - oy_w) * sy_w) >>> FRAC_BITS;
      if (lx > loc_max) begin lx = loc_max; r.sat = 1'b1; end
      if (lx < loc_min) begin lx = loc_min; r.sat = 1'b1; end
      if (ly > loc_max) begin ly = loc_max; r.sat = 1'b1; end
      if (ly < loc_min) begin ly = loc_min; r.sat = 1'b1; end
      rx = ((lx * c_w - ly * s_w) >>> FRAC_BITS) + px_w;
      ry = ((lx * s_w + ly * c_w) >>> FRAC_BITS) + py_w;
      if (rx > w_max) begin rx = w_max; r.sat = 1'b1; end
      if (rx < w_min) begin rx = w_min; r.sat = 1'b1; end
      if (ry > w_max) begin ry = w_max; r.sat = 1'b1; end
      if (ry < w_min) begin ry = w_min; r.sat = 1'b1; end
      r.x[k] = rx[COORD_W-1:0];
      r.y[k] = ry[COORD_W-1:0];
    end
    return r;
  endfunction

  // Per-item wait with occasional stretches of back-to-back traffic.
  function automatic int draw_wait(int side);
    if (quiet_left[side] > 0) begin
      quiet_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) quiet_left[side] = $urandom_range(10, 80);
    return $urandom_range(0, 19);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      glyph_next = '0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        if (tx_item.first) glyph_next = '0;
        expected_corners.push_back(transform_quad(tx_item, glyph_next));
        glyph_next = glyph_next + 1'b1;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (quads_to_send.size() != 0) begin
          tx_item = quads_to_send.pop_front();
          in_first_glyph <= tx_item.first;
          in_x0 <= tx_item.x[0];
          in_y0 <= tx_item.y[0];
          in_x1 <= tx_item.x[1];
          in_y1 <= tx_item.y[1];
          in_x2 <= tx_item.x[2];
          in_y2 <= tx_item.y[2];
          in_x3 <= tx_item.x[3];
          in_y3 <= tx_item.y[3];
          in_valid <= 1'b1;
          tx_gap = draw_wait(0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    quad_result_t got, want;
    int k;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_stall = 0;
    end else if (out_valid && out_ready) begin
      got.base = out_base_index;
      got.x = {out_x3, out_x2, out_x1, out_x0};
      got.y = {out_y3, out_y2, out_y1, out_y0};
      got.sat = out_saturated;
      if (expected_corners.size() == 0) begin
        $error("unexpected transaction: out_base_index %0d", got.base);
        mismatch_count++;
      end else begin
        want = expected_corners.pop_front();
        if (got.base !== want.base) begin
          $error("out_base_index expected %0d actual %0d", want.base, got.base);
          mismatch_count++;
        end
        for (k = 0; k < NUM_LANES; k++) begin
          if (got.x[k] !== want.x[k]) begin
            $error("out_x%0d expected %0d actual %0d", k, $signed(want.x[k]),
                   $signed(got.x[k]));
            mismatch_count++;
          end
          if (got.y[k] !== want.y[k]) begin
            $error("out_y%0d expected %0d actual %0d", k, $signed(want.y[k]),
                   $signed(got.y[k]));
            mismatch_count++;
          end
        end
        if (got.sat !== want.sat) begin
          $error("out_saturated expected %0d actual %0d", want.sat, got.sat);
          mismatch_count++;
        end
      end
      rx_stall = draw_wait(1);
      out_ready <= (rx_stall == 0);
    end else if (!out_ready) begin
      if (rx_stall == 0) out_ready <= 1'b1;
      else rx_stall--;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [COORD_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_ORIGIN_X: xf.origin_x = data;
      CFG_ORIGIN_Y: xf.origin_y = data;
      CFG_SCALE_X:  xf.scale_x = data;
      CFG_SCALE_Y:  xf.scale_y = data;
      CFG_ROT_COS:  xf.rot_cos = data[TRIG_W-1:0];
      CFG_ROT_SIN:  xf.rot_sin = data[TRIG_W-1:0];
      CFG_POS_X:    xf.pos_x = data;
      CFG_POS_Y:    xf.pos_y = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (quads_to_send.size() != 0 || in_valid || expected_corners.size() != 0)
      @(negedge clk);
  endtask

  function automatic logic [COORD_W-1:0] pick_extreme(bit trig);
    case ($urandom_range(0, 4))
      0: return trig ? 32'hFFFE_0000 : 32'h8000_0000;
      1: return trig ? 32'h0001_FFFF : 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return 32'h0001_0000;
    endcase
  endfunction

  // kind 0: plausible layout setting, kind 1: raw bits, kind 2: extreme values
  task automatic load_config(int kind);
    logic [COORD_W-1:0] v[8];
    real ang;
    int i;
    case (kind)
      0: begin
        ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
        v[CFG_ORIGIN_X] = $urandom_range(0, 1 << 25) - (1 << 24);
        v[CFG_ORIGIN_Y] = $urandom_range(0, 1 << 25) - (1 << 24);
        v[CFG_SCALE_X] = $urandom_range(1 << 14, 4 << 16);
        v[CFG_SCALE_Y] = $urandom_range(1 << 14, 4 << 16);
        if ($urandom_range(0, 7) == 0) v[CFG_SCALE_X] = -v[CFG_SCALE_X];
        v[CFG_ROT_COS] = $rtoi($cos(ang) * 65536.0);
        v[CFG_ROT_SIN] = $rtoi($sin(ang) * 65536.0);
        v[CFG_POS_X] = $urandom_range(0, 1 << 27) - (1 << 26);
        v[CFG_POS_Y] = $urandom_range(0, 1 << 27) - (1 << 26);
      end
      1: for (i = 0; i < 8; i++) v[i] = $urandom;
      default: for (i = 0; i < 8; i++)
        v[i] = pick_extreme(i == CFG_ROT_COS || i == CFG_ROT_SIN);
    endcase
    for (i = 0; i < 8; i++) write_reg(cfg_idx_t'(i), v[i]);
  endtask

  function automatic quad_item_t rect_quad(logic first, int bx, int by, int w, int h);
    quad_item_t q;
    q.first = first;
    q.x = {32'(bx), 32'(bx + w), 32'(bx + w), 32'(bx)};
    q.y = {32'(by + h), 32'(by + h), 32'(by), 32'(by)};
    return q;
  endfunction

  function automatic quad_item_t flat_quad(logic first, logic [COORD_W-1:0] xv,
                                           logic [COORD_W-1:0] yv);
    quad_item_t q;
    q.first = first;
    q.x = {4{xv}};
    q.y = {4{yv}};
    return q;
  endfunction

  function automatic quad_item_t make_quad(bit raw);
    quad_item_t q;
    int k;
    if (raw) begin
      q.first = $urandom_range(0, 1);
      for (k = 0; k < NUM_LANES; k++) begin
        q.x[k] = $urandom;
        q.y[k] = $urandom;
      end
      return q;
    end
    return rect_quad($urandom_range(0, 39) == 0,
                     $urandom_range(0, 1 << 24) - (1 << 23),
                     $urandom_range(0, 1 << 24) - (1 << 23),
                     $urandom_range(0, 64 << 16), $urandom_range(0, 64 << 16));
  endfunction

  initial begin
    int ph, n;
    xf = '{origin_x: 0, origin_y: 0, scale_x: 32'sh10000, scale_y: 32'sh10000,
           rot_cos: 18'sh10000, rot_sin: 0, pos_x: 0, pos_y: 0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting: identity transform
    quads_to_send.push_back(flat_quad(1'b1, 32'h0000_0000, 32'h0000_0000));
    quads_to_send.push_back(flat_quad(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    quads_to_send.push_back(flat_quad(1'b0, 32'h8000_0000, 32'h8000_0000));
    quads_to_send.push_back(flat_quad(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    quads_to_send.push_back(flat_quad(1'b0, 32'h5555_5555, 32'hAAAA_AAAA));
    quads_to_send.push_back(rect_quad(1'b0, 10 << 16, 20 << 16, 8 << 16, 12 << 16));
    quads_to_send.push_back(rect_quad(1'b1, -(5 << 16), 3 << 16, 7 << 16, 9 << 16));

    // overflow of the scaled local coordinates
    wait_idle();
    write_reg(CFG_ORIGIN_X, 32'h8000_0000);
    write_reg(CFG_ORIGIN_Y, 32'h7FFF_FFFF);
    write_reg(CFG_SCALE_X, 32'h8000_0000);
    write_reg(CFG_SCALE_Y, 32'h7FFF_FFFF);
    quads_to_send.push_back(flat_quad(1'b0, 32'h7FFF_FFFF, 32'h8000_0000));
    quads_to_send.push_back(flat_quad(1'b0, 32'h8000_0000, 32'h7FFF_FFFF));
    quads_to_send.push_back(flat_quad(1'b0, 32'h0000_0000, 32'h0000_0000));

    // trig beyond unit range, translation at the limits
    wait_idle();
    write_reg(CFG_ORIGIN_X, 32'h0000_0000);
    write_reg(CFG_ORIGIN_Y, 32'h0000_0000);
    write_reg(CFG_SCALE_X, 32'h0001_0000);
    write_reg(CFG_SCALE_Y, 32'h0001_0000);
    write_reg(CFG_ROT_COS, 32'hFFFE_0000);
    write_reg(CFG_ROT_SIN, 32'h0001_FFFF);
    write_reg(CFG_POS_X, 32'h7FFF_FFFF);
    write_reg(CFG_POS_Y, 32'h8000_0000);
    quads_to_send.push_back(rect_quad(1'b0, 1 << 16, 2 << 16, 3 << 16, 4 << 16));
    quads_to_send.push_back(rect_quad(1'b0, -(100 << 16), 50 << 16, 1 << 16, 1 << 16));
    quads_to_send.push_back(flat_quad(1'b0, 32'h0000_0000, 32'h0000_0000));
    quads_to_send.push_back(flat_quad(1'b0, 32'h7FFF_FFFF, 32'h8000_0000));

    // quarter turn at double scale
    wait_idle();
    write_reg(CFG_SCALE_X, 32'h0002_0000);
    write_reg(CFG_SCALE_Y, 32'h0002_0000);
    write_reg(CFG_ROT_COS, 32'h0000_0000);
    write_reg(CFG_ROT_SIN, 32'h0001_0000);
    write_reg(CFG_POS_X, 32'h0010_0000);
    write_reg(CFG_POS_Y, 32'hFFF0_0000);
    write_reg(CFG_ORIGIN_X, 32'h0004_0000);
    quads_to_send.push_back(rect_quad(1'b0, 0, 0, 16 << 16, 16 << 16));
    quads_to_send.push_back(rect_quad(1'b0, -(3 << 16), 7 << 16, 5 << 16, 2 << 16));
    quads_to_send.push_back(flat_quad(1'b1, 32'hFFFF_8000, 32'h0000_8001));

    for (ph = 0; ph < 10; ph++) begin
      wait_idle();
      load_config(ph % 3);
      for (n = 0; n < 195; n++) quads_to_send.push_back(make_quad($urandom_range(0, 3) == 0));
    end

    wait_idle();
    repeat (4 * LATENCY) @(negedge clk);
    if (mismatch_count == 0 && expected_corners.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/gqat_pkg.sv
rtl/gqat_lane.sv
rtl/gqat_merge.sv
rtl/glyph_quad_affine_transform_core.sv
test/glyph_quad_affine_transform_core_tb.sv
